// ===== design/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// Percent escape decoder package
// Shared types, constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_last;
   } rsp_type;

   // The results of one input transaction, oldest in slot 0.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  count;
      logic                        last;
   } group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== design/ped_front.sv =====
// ----------------------------------------------------------------------------
// Percent escape decoder front end
// Classifies each byte against the escape phase and forms its result group.
// ----------------------------------------------------------------------------
module ped_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ped_pkg::req_type   req_data,
   output logic               grp_push,
   output ped_pkg::group_type grp_data
);
   import ped_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   hex_type    cur_hex;
   hex_type    held_hex;
   logic [1:0] n;
   logic [MAX_RESULTS-1:0][7:0] bytes;

   always_comb begin
      cur_hex  = hex_decode(req_data.in_byte);
      held_hex = hex_decode(held_ff);
      phase_in = phase_ff;
      held_in  = held_ff;
      n        = 2'd0;
      bytes    = '0;

      unique case (phase_ff)
         PH_PCT: begin
            if (cur_hex.valid) begin
               held_in  = req_data.in_byte;
               phase_in = PH_DIGIT;
            end else begin
               bytes[n] = PCT_CHAR;
               n = n + 2'd1;
               if (req_data.in_byte != PCT_CHAR) begin
                  bytes[n] = req_data.in_byte;
                  n = n + 2'd1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_DIGIT: begin
            held_in = 8'd0;
            if (cur_hex.valid) begin
               bytes[n] = {held_hex.value, cur_hex.value};
               n = n + 2'd1;
               phase_in = PH_IDLE;
            end else begin
               bytes[n] = PCT_CHAR;
               n = n + 2'd1;
               bytes[n] = held_ff;
               n = n + 2'd1;
               if (req_data.in_byte == PCT_CHAR) begin
                  phase_in = PH_PCT;
               end else begin
                  bytes[n] = req_data.in_byte;
                  n = n + 2'd1;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            // The unused phase code behaves as no escape pending.
            if (req_data.in_byte == PCT_CHAR) begin
               phase_in = PH_PCT;
            end else begin
               bytes[n] = req_data.in_byte;
               n = n + 2'd1;
               phase_in = PH_IDLE;
            end
         end
      endcase

      // At the end of the string any pending escape is flushed verbatim.
      if (req_data.in_last) begin
         if (phase_in == PH_PCT) begin
            bytes[n] = PCT_CHAR;
            n = n + 2'd1;
         end else if (phase_in == PH_DIGIT) begin
            bytes[n] = PCT_CHAR;
            n = n + 2'd1;
            bytes[n] = held_in;
            n = n + 2'd1;
         end
         phase_in = PH_IDLE;
         held_in  = 8'd0;
      end
   end

   assign grp_push       = accept && (n != 2'd0);
   assign grp_data.bytes = bytes;
   assign grp_data.count = n;
   assign grp_data.last  = req_data.in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== design/ped_queue.sv =====
// ----------------------------------------------------------------------------
// Percent escape decoder group queue
// Short queue of result groups between the front and back ends.
// ----------------------------------------------------------------------------
module ped_queue #(
   parameter int unsigned DEPTH = ped_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ped_pkg::group_type        push_data,
   input  logic                      pop,
   output ped_pkg::group_type        head_data,
   output ped_pkg::queue_status_type status
);
   import ped_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   group_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.empty = (count_ff == CW'(0));
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/ped_back.sv =====
// ----------------------------------------------------------------------------
// Percent escape decoder back end
// Serialises each queued group into results, one per cycle while rsp_pop is set.
// ----------------------------------------------------------------------------
module ped_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ped_pkg::group_type        head_data,
   input  ped_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output ped_pkg::rsp_type          rsp_data
);
   import ped_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       run_end;

   assign rsp_empty = q_status.empty;
   assign take      = rsp_pop && !q_status.empty;
   assign run_end   = (idx_ff == head_data.count - 2'd1);

   assign rsp_data.out_byte    = head_data.bytes[idx_ff];
   assign rsp_data.run_last    = run_end;
   assign rsp_data.string_last = run_end && head_data.last;

   // The group leaves the queue together with its final result.
   assign q_pop  = take && run_end;
   assign idx_in = run_end ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (take) begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== design/percent_escape_decoder_top.sv =====
// Each result group is registered in the queue; rsp_ ports show the queue head.
// Throughput: one input byte per cycle while the group queue is not full;
// results leave at one per cycle while rsp_pop is high, so an input yielding two
// or three bytes holds the output while the queue (QUEUE_DEPTH groups) takes input.
// Reset (synchronous) clears the escape phase, held digit and queue; no sweep.
// ----------------------------------------------------------------------------
// Percent escape decoder top level
// Decodes percent escapes in a byte stream; front end, group queue, back end.
// ----------------------------------------------------------------------------
module percent_escape_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ped_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ped_pkg::rsp_type rsp_data
);
   import ped_pkg::*;

   logic             accept;
   logic             grp_push;
   group_type        grp_data;
   group_type        head_data;
   queue_status_type q_status;
   logic             q_pop;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   ped_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .grp_push (grp_push),
      .grp_data (grp_data)
   );

   ped_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .pop       (q_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   ped_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   hex_type req_hex;
   assign req_hex = hex_decode(req_data.in_byte);

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("group queue reports empty and full together");

   a_plain_byte_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_hex.valid && req_data.in_byte != PCT_CHAR) |-> grp_push)
      else $error("a plain byte produced no result group");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.in_last) |-> grp_push)
      else $error("end of string produced no result group");

   a_string_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.string_last) |-> rsp_data.run_last)
      else $error("string end flagged on a result that does not end its run");
`endif

endmodule

// ===== test/percent_escape_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder testbench
// Sends encoded strings through the push/full port and checks every decoded
// byte against a predictor of the decoder, under several idling patterns and
// one long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module percent_escape_decoder_top_tb;

   import ped_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned HOLD_CYCLES    = 60;
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      PHASE_NONE,
      PHASE_PCT,
      PHASE_DIGIT
   } escape_phase_type;

   typedef logic [7:0] byte_queue_type[$];

   logic     clock;
   logic     reset;
   logic     req_push;
   logic     req_full;
   req_type  req_data;
   logic     rsp_empty;
   logic     rsp_pop;
   rsp_type  rsp_data;

   // Predictor state and the decoded bytes still owed by the block.
   escape_phase_type dec_phase;
   logic [7:0]       held_hi;
   rsp_type          decoded_q[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned hold_count;
   bit          hold_req;
   bit          hold_done;

   percent_escape_decoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // Works out the decoded bytes caused by one accepted transaction.
   function automatic void predict_decode(req_type r);
      logic [7:0] outs[3];
      rsp_type    res;
      int         n;
      int         hv;
      logic [7:0] b;
      n  = 0;
      b  = r.in_byte;
      hv = hex_value(b);
      case (dec_phase)
         PHASE_PCT: begin
            if (hv >= 0) begin
               held_hi   = b;
               dec_phase = PHASE_DIGIT;
            end else begin
               outs[n] = PCT_CHAR;
               n++;
               if (b != PCT_CHAR) begin
                  outs[n] = b;
                  n++;
                  dec_phase = PHASE_NONE;
               end
            end
         end
         PHASE_DIGIT: begin
            if (hv >= 0) begin
               outs[n] = 8'((hex_value(held_hi) < 0 ? 0 : hex_value(held_hi)) * 16 + hv);
               n++;
               dec_phase = PHASE_NONE;
            end else begin
               outs[n] = PCT_CHAR;
               outs[n + 1] = held_hi;
               n += 2;
               if (b == PCT_CHAR) begin
                  dec_phase = PHASE_PCT;
               end else begin
                  outs[n] = b;
                  n++;
                  dec_phase = PHASE_NONE;
               end
            end
            if (dec_phase != PHASE_DIGIT) held_hi = 8'h00;
         end
         default: begin
            dec_phase = PHASE_NONE;
            if (b == PCT_CHAR) begin
               dec_phase = PHASE_PCT;
            end else begin
               outs[n] = b;
               n++;
            end
         end
      endcase
      // At the end of a string any pending escape is flushed as it stands.
      if (r.in_last) begin
         if (dec_phase == PHASE_PCT && n < 3) begin
            outs[n] = PCT_CHAR;
            n++;
         end else if (dec_phase == PHASE_DIGIT && n < 2) begin
            outs[n] = PCT_CHAR;
            outs[n + 1] = held_hi;
            n += 2;
         end
         dec_phase = PHASE_NONE;
         held_hi   = 8'h00;
      end
      for (int i = 0; i < n; i++) begin
         res.out_byte    = outs[i];
         res.run_last    = (i == n - 1);
         res.string_last = (i == n - 1) && r.in_last;
         decoded_q = {decoded_q, res};
      end
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR %0t: %s", $realtime, msg);
   endfunction

   // Monitor: predicts on each accepted input and checks each accepted result.
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset) begin
         quiet_cycles++;
         if (req_push && !req_full) begin
            predict_decode(req_data);
            quiet_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            quiet_cycles = 0;
            if (decoded_q.size() == 0) begin
               note_error($sformatf("unexpected result byte %h run_last %b string_last %b",
                                    rsp_data.out_byte, rsp_data.run_last,
                                    rsp_data.string_last));
            end else begin
               exp_res = decoded_q.pop_front();
               if (rsp_data.out_byte !== exp_res.out_byte
                   || rsp_data.run_last !== exp_res.run_last
                   || rsp_data.string_last !== exp_res.string_last) begin
                  note_error($sformatf({"result mismatch: expected byte %h run_last %b ",
                                        "string_last %b, got byte %h run_last %b ",
                                        "string_last %b"},
                                       exp_res.out_byte, exp_res.run_last,
                                       exp_res.string_last, rsp_data.out_byte,
                                       rsp_data.run_last, rsp_data.string_last));
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("percent_escape_decoder_top_tb: done, errors");
            $finish;
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when the test asks for one.
   initial begin
      rsp_pop   <= 1'b0;
      hold_done  = 1'b0;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (!hold_req) hold_done = 1'b0;
         if (hold_req && !hold_done && hold_count == 0) hold_count = HOLD_CYCLES;
         if (hold_count > 0) begin
            rsp_pop <= 1'b0;
            hold_count--;
            if (hold_count == 0) hold_done = 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(logic [7:0] value, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_data.in_byte <= value;
      req_data.in_last <= last;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_bytes(byte_queue_type chars);
      foreach (chars[i]) send_item(chars[i], i == chars.size() - 1);
   endtask

   task automatic send_text(string s);
      byte_queue_type chars;
      for (int i = 0; i < s.len(); i++) chars = {chars, s[i]};
      send_bytes(chars);
   endtask

   function automatic logic [7:0] pick_hex_digit();
      string digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // Characters just outside the hex digit ranges.
   function automatic logic [7:0] pick_near_hex();
      string chars = "/:@G`g";
      return chars[$urandom_range(0, 5)];
   endfunction

   // Mostly well-formed escapes with random content, plus broken ones and noise.
   task automatic send_random_strings(int unsigned n_items);
      byte_queue_type chars;
      int unsigned    sent;
      int unsigned    len;
      int unsigned    k;
      sent = 0;
      while (sent < n_items) begin
         chars.delete();
         len = $urandom_range(1, 8);
         while (chars.size() < len) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
               chars = {chars, PCT_CHAR, pick_hex_digit(), pick_hex_digit()};
            end else if (k < 55) begin
               chars = {chars, PCT_CHAR, pick_hex_digit()};
            end else if (k < 62) begin
               chars = {chars, PCT_CHAR};
            end else if (k < 70) begin
               chars = {chars, pick_near_hex()};
            end else begin
               chars = {chars, 8'($urandom_range(0, 255))};
            end
         end
         send_bytes(chars);
         sent += chars.size();
      end
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_text("%41");
      send_text("%6a%Fb");
      send_text("%G");      // percent then a non-hex byte
      send_text("%4z");     // percent and one digit, then a non-hex byte
      send_text("%4%");     // a new escape starts on the last byte
      send_text("%%");
      send_text("%");       // string ends just after a percent
      send_text("%9");      // string ends after one digit
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_no_idling();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_strings(20);
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 48;
      recv_stall_pct = 0;
      send_random_strings(20);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 48;
      send_random_strings(20);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      send_random_strings(20);
   endtask

   // The receiver holds off while the sender keeps offering, so the block fills.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 1'b1;
      req_push      <= 1'b0;
      @(posedge clock);
      send_random_strings(16);
      wait (hold_done);
      hold_req = 1'b0;
   endtask

   initial begin
      dec_phase      = PHASE_NONE;
      held_hi        = 8'h00;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      error_count    = 0;
      quiet_cycles   = 0;
      hold_req       = 1'b0;
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();

      req_push      <= 1'b0;
      recv_stall_pct = 0;
      wait (decoded_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("percent_escape_decoder_top_tb: done, clean");
      end else begin
         $display("percent_escape_decoder_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ped_pkg.sv
design/ped_front.sv
design/ped_queue.sv
design/ped_back.sv
design/percent_escape_decoder_top.sv
test/percent_escape_decoder_top_tb.sv
